FILE: hw/rtl/calas_pkg.sv
`default_nettype none

package calas_pkg;

    localparam int unsigned OP_W   = 5;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned DEST_W = 3;

    localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;

    typedef enum logic [OP_W-1:0] {
        OP_ORA   = 5'd0,
        OP_AND   = 5'd1,
        OP_EOR   = 5'd2,
        OP_ADC   = 5'd3,
        OP_SBC   = 5'd4,
        OP_CMP   = 5'd5,
        OP_CPX   = 5'd6,
        OP_CPY   = 5'd7,
        OP_DECM  = 5'd8,
        OP_INCM  = 5'd9,
        OP_DEX   = 5'd10,
        OP_DEY   = 5'd11,
        OP_INX   = 5'd12,
        OP_INY   = 5'd13,
        OP_ASLA  = 5'd14,
        OP_ROLA  = 5'd15,
        OP_LSRA  = 5'd16,
        OP_RORA  = 5'd17,
        OP_ASLM  = 5'd18,
        OP_ROLM  = 5'd19,
        OP_LSRM  = 5'd20,
        OP_RORM  = 5'd21
    } t_op;

    typedef enum logic [DEST_W-1:0] {
        DEST_NONE = 3'd0,
        DEST_ACC  = 3'd1,
        DEST_X    = 3'd2,
        DEST_Y    = 3'd3,
        DEST_MEM  = 3'd4
    } t_dest;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] operand;
        logic [BYTE_W-1:0] acc_in;
        logic [BYTE_W-1:0] index_x_in;
        logic [BYTE_W-1:0] index_y_in;
        logic              carry_in;
        logic              overflow_in;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] result_byte;
        t_dest             destination;
        logic              flag_negative;
        logic              flag_zero;
        logic              flag_carry;
        logic              flag_overflow;
    } t_rsp;

endpackage

`default_nettype wire

FILE: hw/rtl/calas_if.sv
`default_nettype none

interface calas_req_if;
    logic       valid;
    logic       ready;
    logic [4:0] op;
    logic [7:0] operand;
    logic [7:0] acc_in;
    logic [7:0] index_x_in;
    logic [7:0] index_y_in;
    logic       carry_in;
    logic       overflow_in;

    modport source (
        output valid, op, operand, acc_in, index_x_in, index_y_in, carry_in, overflow_in,
        input  ready
    );
    modport sink (
        input  valid, op, operand, acc_in, index_x_in, index_y_in, carry_in, overflow_in,
        output ready
    );
endinterface

interface calas_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] result_byte;
    logic [2:0] destination;
    logic       flag_negative;
    logic       flag_zero;
    logic       flag_carry;
    logic       flag_overflow;

    modport source (
        output valid, result_byte, destination, flag_negative, flag_zero,
               flag_carry, flag_overflow,
        input  ready
    );
    modport sink (
        input  valid, result_byte, destination, flag_negative, flag_zero,
               flag_carry, flag_overflow,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/calas_core.sv
`default_nettype none

// One shared 9-bit adder serves add, subtract, compare, inc and dec.
module calas_core (
    input  wire calas_pkg::t_req i_req,
    output calas_pkg::t_rsp      o_rsp
);
    import calas_pkg::*;

    logic [BYTE_W-1:0] add_a;
    logic [BYTE_W-1:0] add_b;
    logic              add_cin;
    logic [BYTE_W:0]   add_sum;
    logic              add_v;
    logic [BYTE_W-1:0] shf_src;
    logic [BYTE_W-1:0] res;
    t_dest             dest;
    logic              c_out;
    logic              v_out;

    // adder operand select
    always_comb begin
        add_a   = i_req.acc_in;
        add_b   = i_req.operand;
        add_cin = i_req.carry_in;
        unique case (i_req.op)
            OP_ADC: begin
                add_b = i_req.operand;
            end
            OP_SBC: begin
                add_b = ~i_req.operand;
            end
            OP_CMP: begin
                add_b   = ~i_req.operand;
                add_cin = 1'b1;
            end
            OP_CPX: begin
                add_a   = i_req.index_x_in;
                add_b   = ~i_req.operand;
                add_cin = 1'b1;
            end
            OP_CPY: begin
                add_a   = i_req.index_y_in;
                add_b   = ~i_req.operand;
                add_cin = 1'b1;
            end
            OP_DECM: begin
                add_a   = i_req.operand;
                add_b   = BYTE_ONES;
                add_cin = 1'b0;
            end
            OP_INCM: begin
                add_a   = i_req.operand;
                add_b   = BYTE_ZERO;
                add_cin = 1'b1;
            end
            OP_DEX: begin
                add_a   = i_req.index_x_in;
                add_b   = BYTE_ONES;
                add_cin = 1'b0;
            end
            OP_DEY: begin
                add_a   = i_req.index_y_in;
                add_b   = BYTE_ONES;
                add_cin = 1'b0;
            end
            OP_INX: begin
                add_a   = i_req.index_x_in;
                add_b   = BYTE_ZERO;
                add_cin = 1'b1;
            end
            OP_INY: begin
                add_a   = i_req.index_y_in;
                add_b   = BYTE_ZERO;
                add_cin = 1'b1;
            end
            default: begin
                add_cin = i_req.carry_in;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{BYTE_W{1'b0}}, add_cin};
    assign add_v   = (add_a[BYTE_W-1] ^ add_sum[BYTE_W-1])
                   & (add_b[BYTE_W-1] ^ add_sum[BYTE_W-1]);

    // shifts: codes below ASL mem work on A
    assign shf_src = (i_req.op < OP_ASLM) ? i_req.acc_in : i_req.operand;

    always_comb begin
        res   = BYTE_ZERO;
        dest  = DEST_NONE;
        c_out = i_req.carry_in;
        v_out = i_req.overflow_in;
        unique case (i_req.op)
            OP_ORA: begin
                res  = i_req.acc_in | i_req.operand;
                dest = DEST_ACC;
            end
            OP_AND: begin
                res  = i_req.acc_in & i_req.operand;
                dest = DEST_ACC;
            end
            OP_EOR: begin
                res  = i_req.acc_in ^ i_req.operand;
                dest = DEST_ACC;
            end
            OP_ADC, OP_SBC: begin
                res   = add_sum[BYTE_W-1:0];
                dest  = DEST_ACC;
                c_out = add_sum[BYTE_W];
                v_out = add_v;
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                res   = add_sum[BYTE_W-1:0];
                dest  = DEST_NONE;
                c_out = add_sum[BYTE_W];
            end
            OP_DECM, OP_INCM: begin
                res  = add_sum[BYTE_W-1:0];
                dest = DEST_MEM;
            end
            OP_DEX, OP_INX: begin
                res  = add_sum[BYTE_W-1:0];
                dest = DEST_X;
            end
            OP_DEY, OP_INY: begin
                res  = add_sum[BYTE_W-1:0];
                dest = DEST_Y;
            end
            OP_ASLA, OP_ASLM: begin
                res   = {shf_src[BYTE_W-2:0], 1'b0};
                dest  = (i_req.op == OP_ASLA) ? DEST_ACC : DEST_MEM;
                c_out = shf_src[BYTE_W-1];
            end
            OP_ROLA, OP_ROLM: begin
                res   = {shf_src[BYTE_W-2:0], i_req.carry_in};
                dest  = (i_req.op == OP_ROLA) ? DEST_ACC : DEST_MEM;
                c_out = shf_src[BYTE_W-1];
            end
            OP_LSRA, OP_LSRM: begin
                res   = {1'b0, shf_src[BYTE_W-1:1]};
                dest  = (i_req.op == OP_LSRA) ? DEST_ACC : DEST_MEM;
                c_out = shf_src[0];
            end
            OP_RORA, OP_RORM: begin
                res   = {i_req.carry_in, shf_src[BYTE_W-1:1]};
                dest  = (i_req.op == OP_RORA) ? DEST_ACC : DEST_MEM;
                c_out = shf_src[0];
            end
            default: begin
                // unused codes: no-op, zero result, C and V pass
                res  = BYTE_ZERO;
                dest = DEST_NONE;
            end
        endcase
    end

    always_comb begin
        o_rsp.result_byte   = res;
        o_rsp.destination   = dest;
        o_rsp.flag_negative = res[BYTE_W-1];
        o_rsp.flag_zero     = (res == BYTE_ZERO);
        o_rsp.flag_carry    = c_out;
        o_rsp.flag_overflow = v_out;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cpu_alu_logic_arith_shift_top.sv
// 6502-style 8-bit ALU as a two-register pipeline. A request transaction carries
// the operation code, operand byte, A, X, Y and the C and V flags; the response
// transaction carries the result byte, its destination (none, A, X, Y or memory)
// and the new N, Z, C and V flags. Decimal mode is not supported. Unused codes
// 22..31 return zero with no destination and pass C and V. The block takes one
// transaction per cycle while the response side accepts: a request accepted
// at a clock edge is held in the request register, then moves on to the
// response register, from which it is offered. Between the two registers sits
// one 9-bit adder shared by add, subtract, compare, increment and decrement,
// plus a shifter and the result mux. Backpressure from the response side stalls
// both registers once both are full; no transaction is dropped or duplicated.

`default_nettype none

module cpu_alu_logic_arith_shift_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    calas_req_if.sink   i_req,
    calas_rsp_if.source o_rsp
);
    import calas_pkg::*;

    // stage 1: captured request
    logic  r_s1_valid;
    logic  n_s1_valid;
    t_req  r_s1;
    t_req  n_s1;

    // stage 2: registered response
    logic  r_out_valid;
    logic  n_out_valid;
    t_rsp  r_out;
    t_rsp  core_rsp;

    logic  s2_load;
    logic  s1_load;

    // response register frees when empty or drained this cycle
    assign s2_load = !r_out_valid || o_rsp.ready;
    // request register frees when empty or moving on to stage 2
    assign s1_load = !r_s1_valid || s2_load;

    assign i_req.ready = s1_load;

    always_comb begin
        n_s1.op          = i_req.op;
        n_s1.operand     = i_req.operand;
        n_s1.acc_in      = i_req.acc_in;
        n_s1.index_x_in  = i_req.index_x_in;
        n_s1.index_y_in  = i_req.index_y_in;
        n_s1.carry_in    = i_req.carry_in;
        n_s1.overflow_in = i_req.overflow_in;
        n_s1_valid       = s1_load ? i_req.valid : r_s1_valid;
        n_out_valid      = s2_load ? r_s1_valid : r_out_valid;
    end

    calas_core u_core (
        .i_req (r_s1),
        .o_rsp (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1 <= n_s1;
        end
        if (s2_load && r_s1_valid) begin
            r_out <= core_rsp;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.result_byte   = r_out.result_byte;
    assign o_rsp.destination   = r_out.destination;
    assign o_rsp.flag_negative = r_out.flag_negative;
    assign o_rsp.flag_zero     = r_out.flag_zero;
    assign o_rsp.flag_carry    = r_out.flag_carry;
    assign o_rsp.flag_overflow = r_out.flag_overflow;

    // an accepted request always lands in stage 1
    a_req_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_s1_valid)
        else $error("accepted request not captured");

    // stage 1 content moving forward always shows up as a response
    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && s2_load |=> r_out_valid)
        else $error("stage 1 transaction lost");

    // N and Z track the result byte
    a_nz_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.flag_negative == r_out.result_byte[BYTE_W-1])
                     && (r_out.flag_zero == (r_out.result_byte == BYTE_ZERO)))
        else $error("N/Z inconsistent with result byte");

    // destination code stays in range
    a_dest_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.destination <= DEST_MEM))
        else $error("destination out of range");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import calas_pkg::*;

    // Codes past the last defined operation: the ALU treats them as no-ops.
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 5'd22;
    localparam logic [OP_W-1:0] OP_LAST_CODE    = 5'd31;

    localparam int  MAX_REPORTED  = 10;
    localparam int  DRAIN_CYCLES  = 8;       // pipeline is two deep; a few spare cycles
    localparam int  STALL_CYCLES  = 64;      // long response hold-off
    localparam longint CYCLE_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;

    calas_req_if req_if ();
    calas_rsp_if rsp_if ();

    cpu_alu_logic_arith_shift_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Predicted responses, oldest first, one per accepted request transaction.
    t_rsp   alu_results_q[$];

    int     mismatches;
    int     results_checked;
    int     ops_sent;
    bit     op_seen [32];
    int     send_idle_pct;
    int     recv_idle_pct;
    int     stall_request;      // set by a test; picked up by the ready process
    longint cycle_count;

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d responses still outstanding",
                     cycle_count, alu_results_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Bit-accurate model of one ALU operation. Binary arithmetic only, no
    // decimal mode. Flags not touched by an operation pass straight through.
    function automatic t_rsp alu_predict(input t_req q);
        t_rsp              p;
        logic [BYTE_W:0]   sum;
        logic [BYTE_W-1:0] rhs;
        logic [BYTE_W-1:0] src;
        logic [BYTE_W-1:0] r;
        t_dest             dest;
        logic              c;
        logic              v;
        c    = q.carry_in;
        v    = q.overflow_in;
        r    = BYTE_ZERO;
        dest = DEST_NONE;
        case (q.op)
            OP_ORA: begin
                r    = q.acc_in | q.operand;
                dest = DEST_ACC;
            end
            OP_AND: begin
                r    = q.acc_in & q.operand;
                dest = DEST_ACC;
            end
            OP_EOR: begin
                r    = q.acc_in ^ q.operand;
                dest = DEST_ACC;
            end
            OP_ADC, OP_SBC: begin
                // subtract is add of the inverted operand; carry = no borrow
                rhs  = (q.op == OP_SBC) ? (q.operand ^ BYTE_ONES) : q.operand;
                sum  = {1'b0, q.acc_in} + {1'b0, rhs} + {{BYTE_W{1'b0}}, q.carry_in};
                r    = sum[BYTE_W-1:0];
                c    = sum[BYTE_W];
                v    = (q.acc_in[7] ^ r[7]) & (rhs[7] ^ r[7]);
                dest = DEST_ACC;
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                src = (q.op == OP_CMP) ? q.acc_in :
                      (q.op == OP_CPX) ? q.index_x_in : q.index_y_in;
                r   = src - q.operand;
                c   = (src >= q.operand);
            end
            OP_DECM: begin
                r    = q.operand - 1'b1;
                dest = DEST_MEM;
            end
            OP_INCM: begin
                r    = q.operand + 1'b1;
                dest = DEST_MEM;
            end
            OP_DEX: begin
                r    = q.index_x_in - 1'b1;
                dest = DEST_X;
            end
            OP_DEY: begin
                r    = q.index_y_in - 1'b1;
                dest = DEST_Y;
            end
            OP_INX: begin
                r    = q.index_x_in + 1'b1;
                dest = DEST_X;
            end
            OP_INY: begin
                r    = q.index_y_in + 1'b1;
                dest = DEST_Y;
            end
            OP_ASLA, OP_ROLA, OP_ASLM, OP_ROLM: begin
                src  = (q.op == OP_ASLA || q.op == OP_ROLA) ? q.acc_in : q.operand;
                dest = (q.op == OP_ASLA || q.op == OP_ROLA) ? DEST_ACC : DEST_MEM;
                // rotates shift the old carry in, memory rotate too
                r    = {src[6:0], (q.op == OP_ROLA || q.op == OP_ROLM) ? q.carry_in : 1'b0};
                c    = src[7];
            end
            OP_LSRA, OP_RORA, OP_LSRM, OP_RORM: begin
                src  = (q.op == OP_LSRA || q.op == OP_RORA) ? q.acc_in : q.operand;
                dest = (q.op == OP_LSRA || q.op == OP_RORA) ? DEST_ACC : DEST_MEM;
                r    = {(q.op == OP_RORA || q.op == OP_RORM) ? q.carry_in : 1'b0, src[7:1]};
                c    = src[0];
            end
            default: begin
                // unused codes: zero result, nowhere to go, C and V untouched
                r    = BYTE_ZERO;
                dest = DEST_NONE;
            end
        endcase
        p.result_byte   = r;
        p.destination   = dest;
        p.flag_negative = r[7];
        p.flag_zero     = (r == BYTE_ZERO);
        p.flag_carry    = c;
        p.flag_overflow = v;
        return p;
    endfunction

    function automatic t_req mk_req(input logic [OP_W-1:0] op, input logic [7:0] m,
                                    input logic [7:0] a, input logic [7:0] x,
                                    input logic [7:0] y, input logic c, input logic v);
        t_req q;
        q.op          = op;
        q.operand     = m;
        q.acc_in      = a;
        q.index_x_in  = x;
        q.index_y_in  = y;
        q.carry_in    = c;
        q.overflow_in = v;
        return q;
    endfunction

    // Byte values lean toward the sign and carry boundaries.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_req random_req();
        logic [OP_W-1:0] op;
        // roughly one in sixteen is an unused code
        if ($urandom_range(15) == 0)
            op = OP_W'($urandom_range(OP_LAST_CODE, OP_FIRST_UNUSED));
        else
            op = OP_W'($urandom_range(OP_RORM, OP_ORA));
        return mk_req(op, pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    // Offer one request transaction, with random idle cycles ahead of it, and
    // record the predicted response once the ALU takes it. Valid stays high on
    // return so back-to-back calls stream without a bubble.
    task automatic send_op(input t_req q);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.op          <= q.op;
        req_if.operand     <= q.operand;
        req_if.acc_in      <= q.acc_in;
        req_if.index_x_in  <= q.index_x_in;
        req_if.index_y_in  <= q.index_y_in;
        req_if.carry_in    <= q.carry_in;
        req_if.overflow_in <= q.overflow_in;
        do @(posedge i_clk); while (!req_if.ready);
        alu_results_q.push_back(alu_predict(q));
        op_seen[q.op] = 1'b1;
        ops_sent++;
    endtask

    // Stop offering and wait for every outstanding response.
    task automatic wait_results_drained();
        req_if.valid <= 1'b0;
        while (alu_results_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Boundary values for each operation, plus the no-op codes.
    task automatic test_directed();
        t_req vec[$];
        send_idle_pct = 0;
        recv_idle_pct = 0;
        vec.push_back(mk_req(OP_ORA,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));  // zero
        vec.push_back(mk_req(OP_AND,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0));
        vec.push_back(mk_req(OP_EOR,  8'hAA, 8'h55, 8'h00, 8'h00, 1'b0, 1'b0));  // negative
        vec.push_back(mk_req(OP_ADC,  8'h01, 8'h7F, 8'h00, 8'h00, 1'b0, 1'b0));  // +overflow
        vec.push_back(mk_req(OP_ADC,  8'h00, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b1));  // carry via C in
        vec.push_back(mk_req(OP_SBC,  8'h01, 8'h80, 8'h00, 8'h00, 1'b1, 1'b0));  // -overflow
        vec.push_back(mk_req(OP_SBC,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));  // borrow in
        vec.push_back(mk_req(OP_CMP,  8'h40, 8'h40, 8'h11, 8'h22, 1'b0, 1'b1));  // equal
        vec.push_back(mk_req(OP_CPX,  8'hFF, 8'h33, 8'h00, 8'h44, 1'b1, 1'b0));  // below
        vec.push_back(mk_req(OP_CPY,  8'h00, 8'h55, 8'h66, 8'hFF, 1'b0, 1'b0));  // above
        vec.push_back(mk_req(OP_DECM, 8'h00, 8'h12, 8'h34, 8'h56, 1'b1, 1'b1));  // wraps
        vec.push_back(mk_req(OP_INCM, 8'hFF, 8'h12, 8'h34, 8'h56, 1'b0, 1'b0));  // wraps
        vec.push_back(mk_req(OP_DEX,  8'h9A, 8'h00, 8'h00, 8'h01, 1'b0, 1'b1));
        vec.push_back(mk_req(OP_DEY,  8'h9A, 8'h00, 8'h01, 8'h80, 1'b1, 1'b0));
        vec.push_back(mk_req(OP_INX,  8'h9A, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0));
        vec.push_back(mk_req(OP_INY,  8'h9A, 8'h00, 8'h00, 8'h7F, 1'b1, 1'b1));
        vec.push_back(mk_req(OP_ASLA, 8'h00, 8'h80, 8'h00, 8'h00, 1'b0, 1'b0));
        vec.push_back(mk_req(OP_ROLA, 8'h00, 8'h80, 8'h00, 8'h00, 1'b1, 1'b0));
        vec.push_back(mk_req(OP_LSRA, 8'hFF, 8'h01, 8'h00, 8'h00, 1'b0, 1'b1));
        vec.push_back(mk_req(OP_RORA, 8'hFF, 8'h01, 8'h00, 8'h00, 1'b1, 1'b0));
        vec.push_back(mk_req(OP_ASLM, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        vec.push_back(mk_req(OP_ROLM, 8'h7F, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1));  // old carry in
        vec.push_back(mk_req(OP_LSRM, 8'h01, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b0));
        vec.push_back(mk_req(OP_RORM, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b0));
        vec.push_back(mk_req(OP_FIRST_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
        vec.push_back(mk_req(OP_LAST_CODE,    8'h80, 8'h7F, 8'h80, 8'h7F, 1'b0, 1'b1));
        foreach (vec[i])
            send_op(vec[i]);
        wait_results_drained();
    endtask

    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
            send_op(random_req());
        wait_results_drained();
    endtask

    // Response side holds off for a long stretch while requests keep coming,
    // so the pipeline fills and pushes back on the request side.
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = STALL_CYCLES;
        repeat (40)
            send_op(random_req());
        wait_results_drained();
    endtask

    // Bursts separated by a full drain, so the pipeline restarts from empty.
    task automatic test_burst_then_drain();
        send_idle_pct = 10;
        recv_idle_pct = 10;
        repeat (3) begin
            repeat (20)
                send_op(random_req());
            wait_results_drained();
        end
    endtask

    // Response ready: random holds per the current idle rate, or a long
    // counted hold-off when a test asks for one.
    initial begin : rsp_ready_gen
        int hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_request > 0) begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Response checker: every response transaction must match the oldest
    // prediction in every field.
    initial begin : rsp_checker
        t_rsp got;
        t_rsp want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                got.result_byte   = rsp_if.result_byte;
                got.destination   = t_dest'(rsp_if.destination);
                got.flag_negative = rsp_if.flag_negative;
                got.flag_zero     = rsp_if.flag_zero;
                got.flag_carry    = rsp_if.flag_carry;
                got.flag_overflow = rsp_if.flag_overflow;
                if (alu_results_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED)
                        $display("%0t: response with nothing outstanding: byte=%02h dest=%0d",
                                 $realtime, got.result_byte, got.destination);
                end else begin
                    want = alu_results_q.pop_front();
                    results_checked++;
                    if (got.result_byte   !== want.result_byte   ||
                        got.destination   !== want.destination   ||
                        got.flag_negative !== want.flag_negative ||
                        got.flag_zero     !== want.flag_zero     ||
                        got.flag_carry    !== want.flag_carry    ||
                        got.flag_overflow !== want.flag_overflow) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTED) begin
                            $display("%0t: response %0d mismatch: expected byte=%02h dest=%0d NZCV=%b%b%b%b",
                                     $realtime, results_checked,
                                     want.result_byte, want.destination,
                                     want.flag_negative, want.flag_zero,
                                     want.flag_carry, want.flag_overflow);
                            $display("    got byte=%02h dest=%0d NZCV=%b%b%b%b",
                                     got.result_byte, got.destination,
                                     got.flag_negative, got.flag_zero,
                                     got.flag_carry, got.flag_overflow);
                        end
                    end
                end
            end
        end
    end

    initial begin : test_sequence
        int codes_hit;
        codes_hit           = 0;
        mismatches          = 0;
        results_checked     = 0;
        ops_sent            = 0;
        cycle_count         = 0;
        stall_request       = 0;
        send_idle_pct       = 0;
        recv_idle_pct       = 0;
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.op          <= OP_ORA;
        req_if.operand     <= BYTE_ZERO;
        req_if.acc_in      <= BYTE_ZERO;
        req_if.index_x_in  <= BYTE_ZERO;
        req_if.index_y_in  <= BYTE_ZERO;
        req_if.carry_in    <= 1'b0;
        req_if.overflow_in <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(500, 17, 48);   // slow consumer
        test_random_traffic(500, 48, 17);   // slow producer
        test_output_stall();
        test_burst_then_drain();
        test_random_traffic(440, 0, 0);     // full rate both sides

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        foreach (op_seen[i])
            if (op_seen[i])
                codes_hit++;
        $display("Covered %0d of 32 operation codes over %0d transactions, %0d responses checked,",
                 codes_hit, ops_sent, results_checked);
        $display("with random and long response stalls, idle producer gaps and full-rate streaming.");
        if (mismatches == 0 && alu_results_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d responses missing", mismatches, alu_results_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
